@@ rtl/tgrq_pkg.sv @@
// ----------------------------------------------------------------------------
// tgrq_pkg: shared types and constants of the tile grid region query block
// Grid limits, fixed-point division constants, field layout of the stream
// beats, register map and the control/status bundles between modules.
// ----------------------------------------------------------------------------
package tgrq_pkg;

  // Grid geometry
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int TILE_PIXELS = 24;
  localparam int TILE_UNITS  = TILE_PIXELS * 16;   // tile side in 1/16 pixel units

  // Tile store
  localparam int ADDR_W = 12;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int VAL_W  = 17;
  localparam int ENT_W  = VAL_W + 1;               // valid bit on top

  // Field widths
  localparam int DIM_W  = 7;
  localparam int ID_W   = 16;
  localparam int POS_W  = 20;
  localparam int SIZE_W = 19;
  localparam int ACT_W  = 2;

  // Scan counter widths
  localparam int COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);

  // Floor division by TILE_UNITS: bias the coordinate to a nonnegative
  // value below 2^V_W, then multiply by a rounded-up reciprocal.
  localparam int V_W         = POS_W + 2;
  localparam int DIV_SHIFT   = V_W + $clog2(TILE_UNITS);
  localparam int R_W         = DIV_SHIFT + 1;
  localparam int P_W         = V_W + R_W;
  localparam int Q_W         = V_W + 2;
  localparam int DIV_BIAS_Q  = ((1 << POS_W) + TILE_UNITS - 1) / TILE_UNITS;
  localparam int DIV_OFFSET  = DIV_BIAS_Q * TILE_UNITS;
  localparam logic [R_W-1:0] DIV_RECIP =
    R_W'(((64'd1 << DIV_SHIFT) + 64'(TILE_UNITS) - 64'd1) / 64'(TILE_UNITS));

  // Actions (carried in tuser)
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RECT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POINT = 2'd2;

  // Slave tdata layout, lowest bit first
  localparam int IDX_LSB    = 0;
  localparam int NUM_LSB    = IDX_LSB + ADDR_W;
  localparam int PX_LSB     = NUM_LSB + ID_W;
  localparam int PY_LSB     = PX_LSB + POS_W;
  localparam int SX_LSB     = PY_LSB + POS_W;
  localparam int SY_LSB     = SX_LSB + SIZE_W;
  localparam int S_FIELDS_W = SY_LSB + SIZE_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

  // Master tdata layout
  localparam int M_FIELDS_W = 2 + VAL_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  // Register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FIRST_ID   = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] map_width;
    logic [DIM_W-1:0] map_height;
    logic [ID_W-1:0]  first_tile_id;
  } cfg_t;

  typedef struct packed {
    logic clr_wr;     // write an empty entry at the sweep address
    logic accept;     // input beat taken this cycle
    logic prep;       // bias coordinates
    logic mul;        // reciprocal multiply
    logic clamp;      // quotients, clamp to map
    logic base;       // set up scan counters
    logic scan;       // issue one store read
    logic out_load;   // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_query;
    logic skip;
    logic scan_last;
    logic hit;
  } dp_stat_t;

  typedef struct packed {
    logic                  skip;
    logic signed [Q_W-1:0] lo;
    logic signed [Q_W-1:0] hi;
  } span_t;

endpackage

@@ rtl/tgrq_regs.sv @@
// ----------------------------------------------------------------------------
// tgrq_regs: configuration registers
// APB-style write and read of map width, map height and first tile id.
// ----------------------------------------------------------------------------
module tgrq_regs
  import tgrq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width     <= '0;
      cfg.map_height    <= '0;
      cfg.first_tile_id <= ID_W'(1);
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_MAP_WIDTH:  cfg.map_width     <= pwdata[DIM_W-1:0];
        REG_MAP_HEIGHT: cfg.map_height    <= pwdata[DIM_W-1:0];
        REG_FIRST_ID:   cfg.first_tile_id <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAP_WIDTH:  prdata = APB_DATA_W'(cfg.map_width);
      REG_MAP_HEIGHT: prdata = APB_DATA_W'(cfg.map_height);
      REG_FIRST_ID:   prdata = APB_DATA_W'(cfg.first_tile_id);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/tgrq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tgrq_ctrl: sequencer
// Runs the clearing sweep, takes input beats, steps a query through its
// arithmetic and scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tgrq_ctrl
  import tgrq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_PREP  = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_CLAMP = 4'd4;
  localparam logic [3:0] ST_BASE  = 4'd5;
  localparam logic [3:0] ST_SCAN  = 4'd6;
  localparam logic [3:0] ST_DRAIN = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.accept = accept;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && stat.in_query) state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_BASE;
      end
      ST_BASE: begin
        cmd.base   = 1'b1;
        state_next = stat.skip ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last || stat.hit) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

@@ rtl/tgrq_dp.sv @@
// ----------------------------------------------------------------------------
// tgrq_dp: datapath
// Tile store memory, coordinate division and clamping, scan counters,
// hit accumulation and the output register.
// ----------------------------------------------------------------------------
module tgrq_dp
  import tgrq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [ACT_W-1:0]    s_tuser,
  output logic [M_DATA_W-1:0] m_tdata
);

  function automatic span_t clamp_span(input logic point, input logic neg,
                                       input logic [P_W-1:0] p0,
                                       input logic [P_W-1:0] p1,
                                       input logic signed [Q_W-1:0] limit);
    logic signed [Q_W-1:0] q0;
    logic signed [Q_W-1:0] q1;
    logic signed [Q_W-1:0] t0;
    logic signed [Q_W-1:0] hi_raw;
    logic                  exact0;
    span_t                 s;
    q0     = $signed(Q_W'(p0 >> DIV_SHIFT)) - Q_W'(DIV_BIAS_Q);
    q1     = $signed(Q_W'(p1 >> DIV_SHIFT)) - Q_W'(DIV_BIAS_Q);
    exact0 = {1'b0, p0[DIV_SHIFT-1:0]} < DIV_RECIP;
    // truncation toward zero: step a negative inexact quotient up by one
    t0     = (neg && !exact0) ? q0 + Q_W'(1) : q0;
    s.lo   = point ? t0 : ((q0 < 0) ? '0 : q0);
    hi_raw = point ? t0 : q1;
    s.hi   = (hi_raw > limit) ? limit : hi_raw;
    s.skip = (s.lo < 0) || (s.lo > s.hi);
    return s;
  endfunction

  // Input fields
  logic [ADDR_W-1:0] in_index;
  logic [ID_W-1:0]   in_number;
  logic [VAL_W-1:0]  in_rel;

  // Captured query
  logic [ACT_W-1:0]         action;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [SIZE_W-1:0]        size_x;
  logic [SIZE_W-1:0]        size_y;
  logic                     is_point;

  // Division pipeline
  logic [V_W-1:0] vx0, vx1, vy0, vy1;
  logic [P_W-1:0] px0, px1, py0, py1;
  span_t          span_x, span_y;
  logic [COL_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;

  // Scan
  logic [COL_W-1:0]  lo_x, hi_x, x;
  logic [ROW_W-1:0]  lo_y, hi_y, y;
  logic              skip;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] raddr;
  logic              rd_pend;
  logic              hit;
  logic [VAL_W-1:0]  value;

  // Store
  logic [ENT_W-1:0]  mem [DEPTH];
  logic [ENT_W-1:0]  rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ENT_W-1:0]  wdata;
  logic [ADDR_W-1:0] clr_cnt;

  // Output register
  logic             o_region_hit;
  logic             o_tile_found;
  logic [VAL_W-1:0] o_tile_value;

  assign in_index  = s_tdata[IDX_LSB +: ADDR_W];
  assign in_number = s_tdata[NUM_LSB +: ID_W];
  assign in_rel    = VAL_W'(in_number) - VAL_W'(cfg.first_tile_id);

  assign is_point = (action == ACT_POINT);
  assign eff_w = (cfg.map_width > DIM_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
                                                       : COL_W'(cfg.map_width);
  assign eff_h = (cfg.map_height > DIM_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS)
                                                     : ROW_W'(cfg.map_height);

  // Store write port: clearing sweep or load beat
  always_comb begin
    we    = cmd.clr_wr || (cmd.accept && (s_tuser == ACT_LOAD));
    waddr = cmd.clr_wr ? clr_cnt : in_index;
    if (cmd.clr_wr || in_number == '0) wdata = '0;
    else wdata = {1'b1, in_rel};
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  assign raddr = row_base + ADDR_W'(x);

  always_ff @(posedge clk) begin
    if (cmd.scan) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_wr) clr_cnt <= clr_cnt + ADDR_W'(1);
  end

  // Capture query fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action <= s_tuser;
      pos_x  <= s_tdata[PX_LSB +: POS_W];
      pos_y  <= s_tdata[PY_LSB +: POS_W];
      size_x <= s_tdata[SX_LSB +: SIZE_W];
      size_y <= s_tdata[SY_LSB +: SIZE_W];
    end
  end

  // Bias edges into nonnegative range (exact modulo 2^V_W)
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      vx0 <= V_W'(pos_x) + V_W'(DIV_OFFSET);
      vx1 <= V_W'(pos_x) + V_W'(size_x) + V_W'(DIV_OFFSET);
      vy0 <= V_W'(pos_y) + V_W'(DIV_OFFSET);
      vy1 <= V_W'(pos_y) + V_W'(size_y) + V_W'(DIV_OFFSET);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      px0 <= P_W'(vx0) * P_W'(DIV_RECIP);
      px1 <= P_W'(vx1) * P_W'(DIV_RECIP);
      py0 <= P_W'(vy0) * P_W'(DIV_RECIP);
      py1 <= P_W'(vy1) * P_W'(DIV_RECIP);
    end
  end

  always_comb begin
    span_x = clamp_span(is_point, pos_x[POS_W-1], px0, px1,
                        $signed(Q_W'(eff_w)) - Q_W'(1));
    span_y = clamp_span(is_point, pos_y[POS_W-1], py0, py1,
                        $signed(Q_W'(eff_h)) - Q_W'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      lo_x <= span_x.lo[COL_W-1:0];
      hi_x <= span_x.hi[COL_W-1:0];
      lo_y <= span_y.lo[ROW_W-1:0];
      hi_y <= span_y.hi[ROW_W-1:0];
      skip <= span_x.skip || span_y.skip;
    end
  end

  // Scan counters: one tile per cycle, row base advances by the map width
  always_ff @(posedge clk) begin
    if (cmd.base) begin
      x        <= lo_x;
      y        <= lo_y;
      row_base <= ADDR_W'(lo_y) * ADDR_W'(eff_w);
    end else if (cmd.scan) begin
      if (x == hi_x) begin
        x        <= lo_x;
        y        <= y + ROW_W'(1);
        row_base <= row_base + ADDR_W'(eff_w);
      end else begin
        x <= x + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rd_pend <= 1'b0;
    else rd_pend <= cmd.scan;
  end

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      hit   <= 1'b0;
      value <= '0;
    end else if (rd_pend && rdata[ENT_W-1]) begin
      hit   <= 1'b1;
      value <= rdata[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_region_hit <= !is_point && hit;
      o_tile_found <= is_point && hit;
      o_tile_value <= (is_point && hit) ? value : '0;
    end
  end

  assign m_tdata = M_DATA_W'({o_tile_value, o_tile_found, o_region_hit});

  always_comb begin
    stat.clr_last  = &clr_cnt;
    stat.in_query  = (s_tuser == ACT_RECT) || (s_tuser == ACT_POINT);
    stat.skip      = skip;
    stat.scan_last = (x == hi_x) && (y == hi_y);
    stat.hit       = hit;
  end

endmodule

@@ rtl/tile_grid_region_query.sv @@
// ----------------------------------------------------------------------------
// tile_grid_region_query: tile grid with rectangle and point queries
// A grid of tile entries filled by load beats and probed by rectangle and
// point queries given in 1/16 pixel fixed point.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   s_*      | in        | s_tvalid / s_tready    | tuser action, tdata fields
//   m_*      | out       | m_tvalid / m_tready    | tdata result fields
//   APB      | in / out  | psel, penable, pready  | paddr, pwdata, prdata
//
// A load beat writes the store in the cycle it is accepted and the block is
// ready again on the next cycle. After a query is accepted, the block biases
// its edges, multiplies by the reciprocal, clamps to the map and sets up the
// scan, then scans, drains the last read and loads the result register. The
// scan ends at the end of the clamped range, or sooner once the first valid
// tile registers as a hit, which lags its read by the read data and hit
// registers; a point scans one tile. An empty range skips the scan. All scan
// reads go through the single store read port.
// After reset a clearing pass writes all 4096 entries, one per cycle, and
// no beat is accepted until it ends; register writes are taken meanwhile.
// A result waits in the output register; the next beat is accepted while
// it waits, and a later query holds its result until the register frees.
// ----------------------------------------------------------------------------
module tile_grid_region_query
  import tgrq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [105:87] size_y, [86:68] size_x, [67:48] pos_y, [47:28] pos_x,
  // [27:12] tile_id, [11:0] tile_index (lowest first: tile_index up)
  input  logic [S_DATA_W-1:0]   s_tdata,
  // [1:0] action
  input  logic [ACT_W-1:0]      s_tuser,
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] region_hit, [1] tile_found, [18:2] tile_value
  output logic [M_DATA_W-1:0]   m_tdata,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Map size and id offset
  tgrq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: clearing pass, query steps, output handoff
  tgrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, division, clamping, scan and result register
  tgrq_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

  // A result is either a rectangle answer or a point answer, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("result flags both set");

  // A point value is shown only with a found tile
  a_value_found: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[18:2] == '0))
    else $error("tile value without a found tile");

  // The clearing pass holds off input right after reset
  a_clear_holds: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready)
    else $error("input accepted before clearing pass");

  // No store read is issued while the block takes input
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !s_tready)
    else $error("scan while ready for input");

endmodule
